@@ hw/rtl/tsd_pkg.sv @@
// tsd_pkg: shared constants, codes and types of the tans stream decoder
// used by every module and interface of the block, depends on nothing
`timescale 1ns / 1ps
package tsd_pkg;

  localparam int MAX_STATES = 4096;
  localparam int IDX_W      = 12;
  localparam int STATE_W    = 13;
  localparam int UNIT_BITS  = 32;
  localparam int SYM_W      = 8;
  localparam int MB_W       = 4;
  localparam int CMD_W      = 2;
  localparam int FBC_W      = 6;
  localparam int REG_W      = 2;
  localparam int LIMIT_W    = 32;
  localparam int RUN_W      = 6;   // index into the result buffer
  localparam int CNT_W      = 7;   // 0..RUN_CAP results
  localparam int STEP_W     = 9;   // 0..256 steps
  localparam int POS_W      = 6;   // bit position across two units
  localparam int NS_W       = 28;  // base shifted by up to 15 bits
  localparam int ENTRY_W    = STATE_W + MB_W + SYM_W;
  localparam int RES_W      = SYM_W + 1;

  localparam logic [CNT_W-1:0]  RUN_CAP    = 7'd64;
  localparam logic [POS_W-1:0]  UNIT_POS   = 6'd32;
  localparam logic [FBC_W-1:0]  FBC_FULL   = 6'd32;
  localparam logic [STATE_W-1:0] RESET_STATE = 13'd4096;

  // input commands
  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNIT     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_TABLE_SIZE  = 2'd0;
  localparam logic [REG_W-1:0] REG_INIT_STATE  = 2'd1;
  localparam logic [REG_W-1:0] REG_FIRST_BITS  = 2'd2;
  localparam logic [REG_W-1:0] REG_OUT_LIMIT   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]     kind;
    logic [IDX_W-1:0]     index;
    logic [STATE_W-1:0]   base;
    logic [MB_W-1:0]      min_bits;
    logic [SYM_W-1:0]     sym;
    logic [UNIT_BITS-1:0] unit;
  } item_t;

  typedef struct packed {
    logic             wr_en;
    logic [RUN_W-1:0] wr_addr;
    logic [SYM_W-1:0] wr_sym;
    logic             wr_done;
    logic             start;
    logic [CNT_W-1:0] count;
    logic             cut;
  } buf_ctl_t;

endpackage

@@ hw/rtl/tsd_if.sv @@
// tsd_if: channel interfaces of the tans stream decoder (items, results, config)
// depends on tsd_pkg for field widths
`timescale 1ns / 1ps
interface tsd_item_if;
  logic                               valid;
  logic                               ready;
  logic [tsd_pkg::CMD_W-1:0]          command;
  logic [tsd_pkg::IDX_W-1:0]          entry_index;
  logic [tsd_pkg::STATE_W-1:0]        entry_base_state;
  logic [tsd_pkg::MB_W-1:0]           entry_min_bits;
  logic [tsd_pkg::SYM_W-1:0]          entry_symbol;
  logic [tsd_pkg::UNIT_BITS-1:0]      unit_data;
  modport source (output valid, command, entry_index, entry_base_state, entry_min_bits,
                  entry_symbol, unit_data, input ready);
  modport sink (input valid, command, entry_index, entry_base_state, entry_min_bits,
                entry_symbol, unit_data, output ready);
endinterface

interface tsd_result_if;
  logic                      valid;
  logic                      ready;
  logic [tsd_pkg::SYM_W-1:0] symbol;
  logic                      last_in_run;
  logic                      run_cut;
  logic                      stream_done;
  modport source (output valid, symbol, last_in_run, run_cut, stream_done, input ready);
  modport sink (input valid, symbol, last_in_run, run_cut, stream_done, output ready);
endinterface

interface tsd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tsd_pkg::REG_W-1:0]   index;
  logic [tsd_pkg::LIMIT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/tsd_front.sv @@
// tsd_front: accepts input items, drops reserved commands, queues the rest
// depends on tsd_pkg and tsd_item_if
`timescale 1ns / 1ps
module tsd_front (
  input  logic            clk,
  input  logic            rst,
  tsd_item_if.sink        item,
  output logic            q_valid,
  input  logic            q_ready,
  output tsd_pkg::item_t  q_item
);

  tsd_pkg::item_t slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign item.ready = (fill != 2'd2);
  assign push = item.valid && item.ready && (item.command != tsd_pkg::CMD_RESERVED);
  assign pop  = q_valid && q_ready;
  assign q_valid = (fill != 2'd0);
  assign q_item  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= '{kind: item.command, index: item.entry_index,
                     base: item.entry_base_state, min_bits: item.entry_min_bits,
                     sym: item.entry_symbol, unit: item.unit_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule

@@ hw/rtl/tsd_outbuf.sv @@
// tsd_outbuf: buffers the symbols of one decode run and drains them as results
// depends on tsd_pkg and tsd_result_if
`timescale 1ns / 1ps
module tsd_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  tsd_pkg::buf_ctl_t ctl,
  output logic              busy,
  tsd_result_if.source      result
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_READ = 2'd1;
  localparam logic [1:0] D_LOAD = 2'd2;
  localparam logic [1:0] D_HOLD = 2'd3;

  logic [tsd_pkg::RES_W-1:0] mem [64];
  logic [tsd_pkg::RES_W-1:0] rdata;
  logic [1:0]                state;
  logic [tsd_pkg::CNT_W-1:0] total;
  logic [tsd_pkg::CNT_W-1:0] rd_idx;
  logic                      cut;
  logic                      out_valid;
  logic [tsd_pkg::SYM_W-1:0] out_sym;
  logic                      out_last;
  logic                      out_cut;
  logic                      out_done;

  assign busy = (state != D_IDLE);
  assign result.valid       = out_valid;
  assign result.symbol      = out_sym;
  assign result.last_in_run = out_last;
  assign result.run_cut     = out_cut;
  assign result.stream_done = out_done;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[ctl.wr_addr] <= {ctl.wr_sym, ctl.wr_done};
    if (state == D_READ) rdata <= mem[rd_idx[tsd_pkg::RUN_W-1:0]];
    if (state == D_LOAD) begin
      out_sym  <= rdata[tsd_pkg::RES_W-1:1];
      out_done <= rdata[0];
      out_last <= (rd_idx == total - 7'd1);
      out_cut  <= cut;
    end
    if (ctl.start) begin
      total <= ctl.count;
      cut   <= ctl.cut;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= D_IDLE;
      out_valid <= 1'b0;
      rd_idx    <= '0;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (ctl.start) begin
            rd_idx <= '0;
            state  <= D_READ;
          end
        end
        D_READ: state <= D_LOAD;
        D_LOAD: begin
          out_valid <= 1'b1;
          rd_idx    <= rd_idx + 7'd1;
          state     <= D_HOLD;
        end
        D_HOLD: begin
          if (result.ready) begin
            out_valid <= 1'b0;
            state     <= (rd_idx == total) ? D_IDLE : D_READ;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/tsd_back.sv @@
// tsd_back: configuration registers, code table and the decode sequencer
// depends on tsd_pkg and tsd_cfg_if; feeds tsd_outbuf through buf_ctl_t
`timescale 1ns / 1ps
module tsd_back (
  input  logic               clk,
  input  logic               rst,
  tsd_cfg_if.sink            cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  tsd_pkg::item_t     q_item,
  input  logic               buf_busy,
  output tsd_pkg::buf_ctl_t  ctl
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOK   = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_APPEND = 2'd3;

  logic [tsd_pkg::ENTRY_W-1:0]   code_mem [tsd_pkg::MAX_STATES];
  logic [tsd_pkg::ENTRY_W-1:0]   rd_entry;

  logic [1:0]                    state;
  logic [tsd_pkg::STATE_W-1:0]   table_size;
  logic [tsd_pkg::LIMIT_W-1:0]   output_limit;
  logic [tsd_pkg::STATE_W-1:0]   dec_state;
  logic [tsd_pkg::POS_W-1:0]     bit_pos;
  logic [tsd_pkg::UNIT_BITS-1:0] held_unit;
  logic                          held;
  logic [tsd_pkg::LIMIT_W-1:0]   emitted;
  logic [tsd_pkg::UNIT_BITS-1:0] cur;
  logic [tsd_pkg::UNIT_BITS-1:0] nxt;
  logic [tsd_pkg::POS_W-1:0]     at;
  logic [tsd_pkg::STEP_W-1:0]    steps;
  logic [tsd_pkg::CNT_W-1:0]     count;
  logic                          cut;
  logic [tsd_pkg::NS_W-1:0]      ns;
  logic [tsd_pkg::POS_W-1:0]     taken;

  logic [tsd_pkg::STATE_W-1:0]   e_base;
  logic [tsd_pkg::MB_W-1:0]      e_mb;
  logic [tsd_pkg::SYM_W-1:0]     e_sym;
  logic [2*tsd_pkg::UNIT_BITS-1:0] stream;
  logic [2*tsd_pkg::UNIT_BITS-1:0] win;
  logic [14:0]                   low_bits;
  logic [tsd_pkg::NS_W-1:0]      ns_first;
  logic [tsd_pkg::POS_W-1:0]     bit_idx;
  logic                          need_decode;
  logic                          start_dec;
  logic                          may_emit;
  logic                          cfg_wr;
  logic [tsd_pkg::IDX_W-1:0]     rd_addr;
  logic [tsd_pkg::STATE_W-1:0]   slot_diff;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  assign {e_base, e_mb, e_sym} = rd_entry;
  assign stream   = {nxt, cur};
  assign win      = stream >> at;
  assign low_bits = win[14:0] & ((15'd1 << e_mb) - 15'd1);
  assign ns_first = ({15'd0, e_base} << e_mb) | {13'd0, low_bits};
  assign bit_idx  = at + taken;
  assign slot_diff = dec_state - table_size;
  assign rd_addr  = slot_diff[tsd_pkg::IDX_W-1:0];

  // a unit or flush decodes only when a unit is already held
  assign need_decode = held && (q_item.kind != tsd_pkg::CMD_LOAD);
  assign q_ready   = (state == S_IDLE) && (!need_decode || !buf_busy);
  assign start_dec = q_valid && q_ready && need_decode;
  assign may_emit  = (state == S_WAIT) && (emitted < output_limit);

  always_comb begin
    ctl.wr_en   = may_emit && (count != tsd_pkg::RUN_CAP);
    ctl.wr_addr = count[tsd_pkg::RUN_W-1:0];
    ctl.wr_sym  = e_sym;
    ctl.wr_done = ((emitted + 32'd1) == output_limit);
    ctl.start   = (state == S_LOOK) && at[tsd_pkg::POS_W-1] && (count != '0);
    ctl.count   = count;
    ctl.cut     = cut;
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready && (q_item.kind == tsd_pkg::CMD_LOAD)) begin
      code_mem[q_item.index] <= {q_item.base, q_item.min_bits, q_item.sym};
    end
    if (state == S_LOOK) rd_entry <= code_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (start_dec) begin
      cur <= held_unit;
      nxt <= (q_item.kind == tsd_pkg::CMD_UNIT) ? q_item.unit : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      table_size   <= tsd_pkg::RESET_STATE;
      output_limit <= '0;
      dec_state    <= tsd_pkg::RESET_STATE;
      bit_pos      <= '0;
      held_unit    <= '0;
      held         <= 1'b0;
      emitted      <= '0;
      at           <= '0;
      steps        <= '0;
      count        <= '0;
      cut          <= 1'b0;
      ns           <= '0;
      taken        <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg.index)
          tsd_pkg::REG_TABLE_SIZE: table_size <= cfg.data[tsd_pkg::STATE_W-1:0];
          tsd_pkg::REG_INIT_STATE: dec_state <= cfg.data[tsd_pkg::STATE_W-1:0];
          tsd_pkg::REG_FIRST_BITS: begin
            if (cfg.data[tsd_pkg::FBC_W-1:0] >= tsd_pkg::FBC_FULL) bit_pos <= '0;
            else bit_pos <= tsd_pkg::UNIT_POS - cfg.data[tsd_pkg::FBC_W-1:0];
          end
          tsd_pkg::REG_OUT_LIMIT: output_limit <= cfg.data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            case (q_item.kind)
              tsd_pkg::CMD_UNIT: begin
                held_unit <= q_item.unit;
                held      <= 1'b1;
              end
              tsd_pkg::CMD_FLUSH: held <= 1'b0;
              default: ;
            endcase
            if (need_decode) begin
              at    <= bit_pos;
              steps <= '0;
              count <= '0;
              cut   <= 1'b0;
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (at[tsd_pkg::POS_W-1]) begin
            bit_pos <= {1'b0, at[tsd_pkg::POS_W-2:0]};
            state   <= S_IDLE;
          end else if (steps[tsd_pkg::STEP_W-1]) begin
            // stuck decoding: skip the rest of the unit
            at <= tsd_pkg::UNIT_POS;
          end else begin
            steps <= steps + 9'd1;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          ns    <= ns_first;
          taken <= {2'b00, e_mb};
          if (may_emit) begin
            if (count != tsd_pkg::RUN_CAP) begin
              emitted <= emitted + 32'd1;
              count   <= count + 7'd1;
            end else begin
              cut <= 1'b1;
            end
          end
          state <= S_APPEND;
        end
        S_APPEND: begin
          if ((ns < {15'd0, table_size}) && !taken[tsd_pkg::POS_W-1]) begin
            ns    <= {ns[tsd_pkg::NS_W-2:0], stream[bit_idx]};
            taken <= taken + 6'd1;
          end else begin
            dec_state <= ns[tsd_pkg::STATE_W-1:0];
            at        <= bit_idx;
            state     <= S_LOOK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    count <= tsd_pkg::RUN_CAP) else $error("result count beyond run cap");
  a_buf_free: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> !buf_busy) else $error("buffer written while draining");
  a_take_cap: assert property (@(posedge clk) disable iff (rst)
    state == S_APPEND |-> taken <= tsd_pkg::UNIT_POS) else $error("read beyond one unit");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start_dec |=> state == S_LOOK) else $error("decode start lost");
`endif

endmodule

@@ hw/rtl/tans_stream_decoder.sv @@
// tans_stream_decoder: top level of the table-driven tans decoder
// depends on tsd_pkg, tsd_if, tsd_front, tsd_back and tsd_outbuf
`timescale 1ns / 1ps
// A compressed unit or flush that decodes works through each symbol in steps
// (table read, state build, check), with an appended renormalization bit at each
// repeated check, all in the single decode sequencer around the 4096-entry code
// table. Decoded symbols of one unit collect in a 64-entry buffer and drain one
// transfer at a time, each held until taken; the next decoding unit waits until
// the buffer is empty, while loads and the first unit proceed. A 2-entry queue
// accepts items while the decoder is busy. There is no clearing pass after reset.
module tans_stream_decoder (
  input  logic         clk,
  input  logic         rst,
  tsd_item_if.sink     item,
  tsd_result_if.source result,
  tsd_cfg_if.sink      cfg
);

  logic              q_valid;
  logic              q_ready;
  tsd_pkg::item_t    q_item;
  logic              buf_busy;
  tsd_pkg::buf_ctl_t ctl;

  tsd_front u_front (
    .clk(clk), .rst(rst), .item(item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  tsd_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .buf_busy(buf_busy), .ctl(ctl)
  );

  tsd_outbuf u_outbuf (
    .clk(clk), .rst(rst), .ctl(ctl), .busy(buf_busy), .result(result)
  );

endmodule

@@ sim/tb_tans_stream_decoder.sv @@
// tb_tans_stream_decoder: self-checking testbench of the tans stream decoder
// loads code tables, streams compressed units and checks every decoded symbol
// against a built-in predictor; depends on tsd_pkg, tsd_if and the rtl top
`timescale 1ns / 1ps
module tb_tans_stream_decoder;

  typedef struct packed {
    logic [tsd_pkg::SYM_W-1:0] sym;
    logic                      last;
    logic                      cut;
    logic                      done;
  } sym_result_t;

  localparam int STEP_CAP    = 256;
  localparam int SETTLE_WAIT = 3000;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst;

  tsd_item_if   item_ch ();
  tsd_result_if res_ch ();
  tsd_cfg_if    cfg_ch ();

  tans_stream_decoder DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // predictor state
  logic [tsd_pkg::STATE_W-1:0]   slot_base [tsd_pkg::MAX_STATES];
  logic [tsd_pkg::MB_W-1:0]      slot_bits [tsd_pkg::MAX_STATES];
  logic [tsd_pkg::SYM_W-1:0]     slot_sym  [tsd_pkg::MAX_STATES];
  int                            num_states;
  int                            cur_state;
  int                            bit_pos;
  logic [tsd_pkg::LIMIT_W-1:0]   out_limit;
  logic [tsd_pkg::LIMIT_W-1:0]   emitted;
  logic [tsd_pkg::UNIT_BITS-1:0] held_unit;
  bit                            unit_held;

  tsd_pkg::item_t pending_items [$];
  sym_result_t    symbol_q [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  send_hold;
  bit  hold_req;
  int  hold_left;
  int  mismatches;
  int  cycles;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic stream_bit(logic [tsd_pkg::UNIT_BITS-1:0] cur,
                                      logic [tsd_pkg::UNIT_BITS-1:0] nxt, int pos);
    if (pos < tsd_pkg::UNIT_BITS) return cur[pos];
    if (pos < 2 * tsd_pkg::UNIT_BITS) return nxt[pos-tsd_pkg::UNIT_BITS];
    return 1'b0;
  endfunction

  // decode the held unit, with nxt supplying bits that run past its end
  task automatic decode_held(logic [tsd_pkg::UNIT_BITS-1:0] cur,
                             logic [tsd_pkg::UNIT_BITS-1:0] nxt);
    int              at;
    int              steps;
    int              taken;
    int              slot;
    bit              cut;
    longint unsigned ns;
    sym_result_t     run [$];
    at = bit_pos;
    steps = 0;
    cut = 1'b0;
    while (at < tsd_pkg::UNIT_BITS) begin
      if (steps >= STEP_CAP) begin
        at = tsd_pkg::UNIT_BITS;
        break;
      end
      steps++;
      slot = (cur_state - num_states) & (tsd_pkg::MAX_STATES - 1);
      taken = int'(slot_bits[slot]);
      ns = longint'(slot_base[slot]) << taken;
      for (int i = 0; i < taken; i++)
        ns += longint'(stream_bit(cur, nxt, at + i)) << i;
      while (ns < num_states && taken < tsd_pkg::UNIT_BITS) begin
        ns = (ns << 1) + longint'(stream_bit(cur, nxt, at + taken));
        taken++;
      end
      if (emitted < out_limit) begin
        if (run.size() < tsd_pkg::RUN_CAP) begin
          emitted = emitted + 1;
          run.push_back('{slot_sym[slot], 1'b0, 1'b0, emitted == out_limit});
        end else begin
          cut = 1'b1;
        end
      end
      cur_state = int'(ns & (2 * tsd_pkg::MAX_STATES - 1));
      at += taken;
    end
    bit_pos = at - tsd_pkg::UNIT_BITS;
    foreach (run[k]) begin
      run[k].cut = cut;
      run[k].last = (k == run.size() - 1);
      symbol_q.push_back(run[k]);
    end
  endtask

  task automatic predict_item(tsd_pkg::item_t it);
    case (it.kind)
      tsd_pkg::CMD_LOAD: begin
        slot_base[it.index] = it.base;
        slot_bits[it.index] = it.min_bits;
        slot_sym[it.index] = it.sym;
      end
      tsd_pkg::CMD_UNIT: begin
        if (unit_held) decode_held(held_unit, it.unit);
        held_unit = it.unit;
        unit_held = 1'b1;
      end
      tsd_pkg::CMD_FLUSH: begin
        if (unit_held) decode_held(held_unit, '0);
        unit_held = 1'b0;
      end
      default: ;
    endcase
  endtask

  // sender: holds an offered item until it is taken
  always @(posedge clk) begin : drive_items
    bit took;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      took = item_ch.valid && item_ch.ready;
      if (took) begin
        predict_item(pending_items[0]);
        void'(pending_items.pop_front());
      end
      if (!item_ch.valid || took) begin
        if (pending_items.size() > 0 && !send_hold &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          item_ch.valid <= 1'b1;
          item_ch.command <= pending_items[0].kind;
          item_ch.entry_index <= pending_items[0].index;
          item_ch.entry_base_state <= pending_items[0].base;
          item_ch.entry_min_bits <= pending_items[0].min_bits;
          item_ch.entry_symbol <= pending_items[0].sym;
          item_ch.unit_data <= pending_items[0].unit;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_req) hold_left <= 600;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else res_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_symbols
    sym_result_t got;
    sym_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.symbol, res_ch.last_in_run, res_ch.run_cut, res_ch.stream_done};
      if (symbol_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected symbol transfer: sym=%0d last=%0b cut=%0b done=%0b",
                   got.sym, got.last, got.cut, got.done);
      end else begin
        want = symbol_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected sym=%0d last=%0b cut=%0b done=%0b, ",
                      "got sym=%0d last=%0b cut=%0b done=%0b"},
                     want.sym, want.last, want.cut, want.done,
                     got.sym, got.last, got.cut, got.done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL tans_stream_decoder");
      $finish;
    end
  end

  task automatic cfg_write(logic [tsd_pkg::REG_W-1:0] idx, logic [tsd_pkg::LIMIT_W-1:0] val);
    int fbc;
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      tsd_pkg::REG_TABLE_SIZE: num_states = val & 13'h1fff;
      tsd_pkg::REG_INIT_STATE: cur_state = val & 13'h1fff;
      tsd_pkg::REG_FIRST_BITS: begin
        fbc = val & 6'h3f;
        if (fbc > tsd_pkg::UNIT_BITS) fbc = tsd_pkg::UNIT_BITS;
        bit_pos = tsd_pkg::UNIT_BITS - fbc;
      end
      tsd_pkg::REG_OUT_LIMIT: out_limit = val;
      default: ;
    endcase
  endtask

  // wait until every item is taken and every symbol has come back
  task automatic drain();
    @(negedge clk);
    while (pending_items.size() > 0 || item_ch.valid || symbol_q.size() > 0)
      @(negedge clk);
  endtask

  function automatic tsd_pkg::item_t make_item(logic [tsd_pkg::CMD_W-1:0] kind);
    tsd_pkg::item_t it;
    logic [31:0]    r;
    int             v;
    it.kind = kind;
    r = $urandom;
    it.index = r[tsd_pkg::IDX_W-1:0];
    r = $urandom;
    it.base = r[tsd_pkg::STATE_W-1:0];
    v = $urandom_range(0, 12);
    it.min_bits = v[tsd_pkg::MB_W-1:0];
    r = $urandom;
    it.sym = r[tsd_pkg::SYM_W-1:0];
    it.unit = $urandom;
    return it;
  endfunction

  // slot whose next state always lands in l..2l-1; wild slots only with a full table
  function automatic tsd_pkg::item_t make_slot(int idx, int l, bit wild);
    tsd_pkg::item_t it;
    int             mmax;
    int             mb;
    int             b;
    it = make_item(tsd_pkg::CMD_LOAD);
    it.index = idx[tsd_pkg::IDX_W-1:0];
    if (!wild) begin
      mmax = 0;
      while (mmax < 12 && ((2 * l) >> (mmax + 1)) >= 2) mmax++;
      mb = $urandom_range(0, mmax);
      if (mb == 0) mb = $urandom_range(0, mmax);
      it.min_bits = mb[tsd_pkg::MB_W-1:0];
      b = $urandom_range(1, ((2 * l) >> mb) - 1);
      it.base = b[tsd_pkg::STATE_W-1:0];
    end
    return it;
  endfunction

  task automatic random_items(int l, int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) pending_items.push_back(make_item(tsd_pkg::CMD_UNIT));
      else if (r < 82) pending_items.push_back(make_item(tsd_pkg::CMD_FLUSH));
      else if (r < 88) pending_items.push_back(make_item(tsd_pkg::CMD_RESERVED));
      else pending_items.push_back(make_slot($urandom_range(0, l - 1), l,
                                             l == tsd_pkg::MAX_STATES));
    end
    pending_items.push_back(make_item(tsd_pkg::CMD_FLUSH));
  endtask

  task automatic set_mode(int m);
    case (m)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  task automatic small_phase(int m, int l, int init, int fbc,
                             logic [tsd_pkg::LIMIT_W-1:0] lim, int n, bit squeeze);
    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    set_mode(m);
    cfg_write(tsd_pkg::REG_TABLE_SIZE, l);
    cfg_write(tsd_pkg::REG_INIT_STATE, init);
    cfg_write(tsd_pkg::REG_FIRST_BITS, fbc);
    cfg_write(tsd_pkg::REG_OUT_LIMIT, lim);
    @(negedge clk);
    for (int i = 0; i < l; i++) pending_items.push_back(make_slot(i, l, 1'b0));
    if (squeeze) begin
      hold_req <= 1'b1;
      @(posedge clk);
      hold_req <= 1'b0;
      @(negedge clk);
    end
    random_items(l, n / 2);
    if (squeeze) begin
      // sender pause until the decoder has caught up
      drain();
      repeat (SETTLE_WAIT) @(posedge clk);
    end
    @(negedge clk);
    random_items(l, n - n / 2);
  endtask

  initial begin
    tsd_pkg::item_t it;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.command = tsd_pkg::CMD_LOAD;
    item_ch.entry_index = '0;
    item_ch.entry_base_state = '0;
    item_ch.entry_min_bits = '0;
    item_ch.entry_symbol = '0;
    item_ch.unit_data = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = tsd_pkg::REG_TABLE_SIZE;
    cfg_ch.data = '0;
    send_hold = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    cycles = 0;
    num_states = 4096;
    cur_state = 4096;
    bit_pos = 0;
    out_limit = '0;
    emitted = '0;
    held_unit = '0;
    unit_held = 1'b0;
    set_mode(0);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // small table that starts on a self-looping slot: stuck decoding and run cut
    cfg_write(tsd_pkg::REG_TABLE_SIZE, 8);
    cfg_write(tsd_pkg::REG_INIT_STATE, 15);
    cfg_write(tsd_pkg::REG_FIRST_BITS, 32);
    cfg_write(tsd_pkg::REG_OUT_LIMIT, 32'hffff_ffff);
    @(negedge clk);
    it = make_item(tsd_pkg::CMD_LOAD);
    it.index = 12'hfff; it.base = 13'h1fff; it.min_bits = 4'd12; it.sym = 8'hff;
    pending_items.push_back(it);
    it.index = '0; it.base = '0; it.min_bits = '0; it.sym = '0;
    pending_items.push_back(it);
    pending_items.push_back(make_item(tsd_pkg::CMD_RESERVED));
    pending_items.push_back(make_item(tsd_pkg::CMD_FLUSH));     // flush with nothing held
    for (int i = 0; i < 8; i++) pending_items.push_back(make_slot(i, 8, 1'b0));
    // no-read slot pointing at itself
    it.index = 12'd7; it.base = 13'd15; it.min_bits = '0; it.sym = 8'ha5;
    pending_items.push_back(it);
    it = make_item(tsd_pkg::CMD_UNIT);
    it.unit = '0;
    pending_items.push_back(it);                      // first unit only stored
    it.unit = 32'hffff_ffff;
    pending_items.push_back(it);
    pending_items.push_back(make_slot(7, 8, 1'b0));
    pending_items.push_back(make_item(tsd_pkg::CMD_UNIT));
    pending_items.push_back(make_item(tsd_pkg::CMD_FLUSH));
    random_items(8, 16);
    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    cfg_write(tsd_pkg::REG_INIT_STATE, 13);
    @(negedge clk);
    random_items(8, 10);

    small_phase(1, 2, 3, 1, 32'hffff_ffff, 30, 1'b0);
    small_phase(2, 16, 20, 0, 32'hffff_ffff, 30, 1'b1);
    small_phase(3, 32, 40, 40, 32'hffff_ffff, 30, 1'b0);
    small_phase(0, 32, 50, 17, 32'hffff_ffff, 30, 1'b1);
    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    small_phase(3, 8, 12, 32, emitted + 25, 30, 1'b0);
    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    small_phase(1, 32, 40, 9, 32'd0, 10, 1'b0);
    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    small_phase(2, 16, 20, 28, 32'hffff_ffff, 30, 1'b0);

    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatches == 0 && symbol_q.size() == 0) begin
      $display("PASS tans_stream_decoder");
    end else begin
      $display("FAIL tans_stream_decoder");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tsd_pkg.sv
hw/rtl/tsd_if.sv
hw/rtl/tsd_front.sv
hw/rtl/tsd_outbuf.sv
hw/rtl/tsd_back.sv
hw/rtl/tans_stream_decoder.sv
sim/tb_tans_stream_decoder.sv
